// ===== rtl/core/plst_pkg.sv =====
// Shared types and constants for the positional list store.
// Holds field widths, action and status codes, and the result record.
// No dependencies.
package plst_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 5;
    localparam int MASK_W   = 32;

    localparam logic [MASK_W-1:0] MASK_RESET = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT     = 2'd0,
        ACT_REMOVE_AT  = 2'd1,
        ACT_REMOVE_VAL = 2'd2,
        ACT_TRAVERSE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   element_value;
        logic [INDEX_W-1:0]   element_index;
        logic [COUNT_W-1:0]   entry_count;
        logic                 last;
    } t_result;

endpackage

// ===== rtl/core/plst_mem.sv =====
// Entry memory of the positional list store: one write port, one read port,
// read data registered and held until the next read. Depends on nothing.
module plst_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic             i_re,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== rtl/core/plst_oreg.sv =====
// Output register of the positional list store: holds one result transaction
// while the consumer stalls. Depends on plst_pkg.
module plst_oreg
    import plst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/plst_seq.sv =====
// Sequencer of the positional list store: decodes each action, walks the
// entry memory through its read port and writes shifted entries back.
// Depends on plst_pkg; drives plst_mem and plst_oreg.
module plst_seq
    import plst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [POS_W-1:0]      i_position,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_cfg_wr_en,
    input  logic [MASK_W-1:0]     i_cfg_wr_data,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_wa,
    output logic [WORD_WIDTH-1:0] o_mem_wd,
    output logic                  o_mem_re,
    output logic [AW-1:0]         o_mem_ra,
    input  logic [WORD_WIDTH-1:0] i_mem_rd,
    input  logic                  i_out_free,
    output logic                  o_emit,
    output t_result               o_res
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PUT   = 6'b001000,
        S_RESP  = 6'b010000,
        S_TRAV  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    t_action               r_act, n_act;
    t_status               r_status, n_status;
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_tgt, n_tgt;
    logic [AW-1:0]         r_ra, n_ra;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_rp, n_rp;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_up, n_up;
    logic                  r_rd_vld, n_rd_vld;
    logic [MASK_W-1:0]     r_mask;

    logic [CW-1:0]         ins_pos;
    logic [CW-1:0]         scan_left;
    logic                  hit;
    logic                  trav_last;

    assign o_in_stall = (r_state != S_IDLE);

    assign ins_pos   = (i_position > POS_W'(r_count)) ? r_count : CW'(i_position);
    assign scan_left = r_count - CW'(1) - CW'(r_ra);
    assign hit       = (r_act == ACT_REMOVE_AT)
                    || (((i_mem_rd ^ r_val) & WORD_WIDTH'(r_mask)) == '0);
    assign trav_last = ((CW'(r_ra) + CW'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_status = r_status;
        n_val    = r_val;
        n_tgt    = r_tgt;
        n_ra     = r_ra;
        n_count  = r_count;
        n_rp     = r_rp;
        n_left   = r_left;
        n_up     = r_up;
        n_rd_vld = r_rd_vld;

        o_mem_we = 1'b0;
        o_mem_wa = r_up ? (r_ra + AW'(1)) : (r_ra - AW'(1));
        o_mem_wd = i_mem_rd;
        o_mem_re = 1'b0;
        o_mem_ra = r_rp[AW-1:0];

        o_emit = 1'b0;
        o_res  = '{status:        r_status,
                   element_value: VALUE_W'(r_val),
                   element_index: INDEX_W'(r_tgt),
                   entry_count:   COUNT_W'(r_count),
                   last:          1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = t_action'(i_action);
                    n_val    = WORD_WIDTH'(i_value);
                    n_rd_vld = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_val    = '0;
                                n_tgt    = '0;
                                n_state  = S_RESP;
                            end else begin
                                n_tgt   = ins_pos[AW-1:0];
                                n_left  = r_count - ins_pos;
                                n_rp    = r_count - CW'(1);
                                n_up    = 1'b1;
                                n_state = (r_count > ins_pos) ? S_SHIFT : S_PUT;
                            end
                        end
                        ACT_REMOVE_AT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_val    = '0;
                                n_tgt    = '0;
                                n_state  = S_RESP;
                            end else if (POS_W'(r_count) <= i_position) begin
                                n_status = ST_MISS;
                                n_val    = '0;
                                n_tgt    = '0;
                                n_state  = S_RESP;
                            end else begin
                                n_rp    = CW'(i_position);
                                n_state = S_SCAN;
                            end
                        end
                        ACT_REMOVE_VAL, ACT_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_val    = '0;
                                n_tgt    = '0;
                                n_state  = S_RESP;
                            end else begin
                                n_rp    = '0;
                                n_state = (t_action'(i_action) == ACT_TRAVERSE)
                                        ? S_TRAV : S_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                // one read in flight at a time; compare when it returns
                if (r_rd_vld) begin
                    n_rd_vld = 1'b0;
                    if (hit) begin
                        n_val  = i_mem_rd;
                        n_tgt  = r_ra;
                        n_rp   = CW'(r_ra) + CW'(1);
                        n_left = scan_left;
                        n_up   = 1'b0;
                        if (scan_left == '0) begin
                            n_count  = r_count - CW'(1);
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end else if (r_rp == r_count) begin
                        n_status = ST_MISS;
                        n_val    = '0;
                        n_tgt    = '0;
                        n_state  = S_RESP;
                    end
                end else begin
                    o_mem_re = 1'b1;
                    n_ra     = r_rp[AW-1:0];
                    n_rp     = r_rp + CW'(1);
                    n_rd_vld = 1'b1;
                end
            end

            S_SHIFT: begin
                // write back the entry read last cycle one slot up or down
                if (r_rd_vld) begin
                    o_mem_we = 1'b1;
                end
                if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_ra     = r_rp[AW-1:0];
                    n_rp     = r_up ? (r_rp - CW'(1)) : (r_rp + CW'(1));
                    n_left   = r_left - CW'(1);
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        if (r_up) begin
                            n_state = S_PUT;
                        end else begin
                            n_count  = r_count - CW'(1);
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end
                    end
                end
            end

            S_PUT: begin
                o_mem_we = 1'b1;
                o_mem_wa = r_tgt;
                o_mem_wd = r_val;
                n_count  = r_count + CW'(1);
                n_status = ST_DONE;
                n_state  = S_RESP;
            end

            S_RESP: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_TRAV: begin
                if (r_rd_vld && i_out_free) begin
                    o_emit   = 1'b1;
                    o_res    = '{status:        ST_DONE,
                                 element_value: VALUE_W'(i_mem_rd),
                                 element_index: INDEX_W'(r_ra),
                                 entry_count:   COUNT_W'(r_count),
                                 last:          trav_last};
                    n_rd_vld = 1'b0;
                    if (trav_last) begin
                        n_state = S_IDLE;
                    end
                end
                // read data stays in the memory output until it is taken
                if ((r_rp < r_count) && (!r_rd_vld || i_out_free)) begin
                    o_mem_re = 1'b1;
                    n_ra     = r_rp[AW-1:0];
                    n_rp     = r_rp + CW'(1);
                    n_rd_vld = 1'b1;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_mask   <= MASK_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_val    <= n_val;
        r_tgt    <= n_tgt;
        r_ra     <= n_ra;
        r_rp     <= n_rp;
        r_left   <= n_left;
        r_up     <= n_up;
    end

endmodule

// ===== rtl/core/positional_list_store_top.sv =====
// Positional list store: an ordered list of up to CAPACITY words held in a
// single-port-read, single-port-write memory with a registered read. Each input
// transaction runs to completion before the next is taken. Insert moves the
// entries above the position up one slot each, then writes the new word; remove
// at position moves the entries behind it down one slot each; remove by value
// first reads the entries one at a time up to the match, or through all of them
// on a miss. Rejected and empty-list actions only return a status. Traverse reads
// the entries in order and emits one entry per cycle while the consumer does not
// stall. A stalled consumer holding the output register delays any of these.
// All of this work goes through the memory's one read port.
// Depends on plst_pkg, plst_mem, plst_oreg and plst_seq.
module positional_list_store_top
    import plst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_cfg_wr_en,
    input  logic [MASK_W-1:0]   i_cfg_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_element_value,
    output logic [INDEX_W-1:0]  o_element_index,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [WORD_WIDTH-1:0] mem_wd;
    logic                  mem_re;
    logic [AW-1:0]         mem_ra;
    logic [WORD_WIDTH-1:0] mem_rd;
    logic                  out_free;
    logic                  emit;
    t_result               seq_res;
    t_result               out_res;

    plst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    plst_seq #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem_we      (mem_we),
        .o_mem_wa      (mem_wa),
        .o_mem_wd      (mem_wd),
        .o_mem_re      (mem_re),
        .o_mem_ra      (mem_ra),
        .i_mem_rd      (mem_rd),
        .i_out_free    (out_free),
        .o_emit        (emit),
        .o_res         (seq_res)
    );

    plst_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_res   (seq_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .i_stall (i_out_stall)
    );

    assign o_status        = out_res.status;
    assign o_element_value = out_res.element_value;
    assign o_element_index = out_res.element_index;
    assign o_entry_count   = out_res.entry_count;
    assign o_last          = out_res.last;

endmodule

// ===== test/tb_positional_list_store_top.sv =====
// Self-checking testbench for positional_list_store_top: insert, remove and traverse
// transactions run against an in-bench list model, with random stalls on both sides.
// Depends on plst_pkg and the positional_list_store_top RTL.
module tb_positional_list_store_top;
    import plst_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int DRAIN_CYCLES = 80;
    localparam int WATCHDOG_MAX = 4000;
    localparam int NUM_PHASES   = 4;
    localparam int RAND_PER_PHASE = 56;

    typedef struct packed {
        t_action            action;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_list_op;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_list_op            drv_op = '0;
    logic                cfg_wr_en = 1'b0;
    logic [MASK_W-1:0]   cfg_wr_data = '0;
    logic                out_stall = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [VALUE_W-1:0]  o_element_value;
    logic [INDEX_W-1:0]  o_element_index;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_last;

    // list model
    logic [VALUE_W-1:0]  model_words [CAPACITY];
    int unsigned         model_len = 0;
    logic [MASK_W-1:0]   model_mask = MASK_RESET;

    t_list_op            pending_ops [$];
    t_result             expected_results [$];
    logic [VALUE_W-1:0]  word_pool [8];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  fail_count = 0;
    int                  quiet_cycles = 0;

    positional_list_store_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (drv_op.action),
        .i_position      (drv_op.position),
        .i_value         (drv_op.value),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_status        (o_status),
        .o_element_value (o_element_value),
        .o_element_index (o_element_index),
        .o_entry_count   (o_entry_count),
        .o_last          (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void push_expect(t_status st, logic [VALUE_W-1:0] val,
                                        int unsigned idx, logic fin);
        t_result r;
        r.status        = st;
        r.element_value = val;
        r.element_index = INDEX_W'(idx);
        r.entry_count   = COUNT_W'(model_len);
        r.last          = fin;
        expected_results.push_back(r);
    endfunction

    function automatic logic [VALUE_W-1:0] drop_entry(int unsigned p);
        logic [VALUE_W-1:0] gone;
        gone = model_words[p];
        for (int unsigned i = p; i + 1 < model_len; i++)
            model_words[i] = model_words[i + 1];
        model_len--;
        return gone;
    endfunction

    function automatic void predict_list_op(t_list_op op);
        int unsigned        p;
        int unsigned        hit;
        logic [VALUE_W-1:0] gone;
        p = op.position;
        case (op.action)
            ACT_INSERT: begin
                if (model_len >= CAPACITY) begin
                    push_expect(ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (p > model_len) p = model_len;
                    for (int unsigned i = model_len; i > p; i--)
                        model_words[i] = model_words[i - 1];
                    model_words[p] = op.value;
                    model_len++;
                    push_expect(ST_DONE, op.value, p, 1'b1);
                end
            end
            ACT_REMOVE_AT: begin
                if (model_len == 0) begin
                    push_expect(ST_EMPTY, '0, 0, 1'b1);
                end else if (p >= model_len) begin
                    push_expect(ST_MISS, '0, 0, 1'b1);
                end else begin
                    gone = drop_entry(p);
                    push_expect(ST_DONE, gone, p, 1'b1);
                end
            end
            ACT_REMOVE_VAL: begin
                if (model_len == 0) begin
                    push_expect(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    hit = model_len;
                    for (int unsigned i = 0; i < model_len; i++) begin
                        if (((model_words[i] ^ op.value) & model_mask) == '0) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit == model_len) begin
                        push_expect(ST_MISS, '0, 0, 1'b1);
                    end else begin
                        gone = drop_entry(hit);
                        push_expect(ST_DONE, gone, hit, 1'b1);
                    end
                end
            end
            default: begin
                if (model_len == 0) begin
                    push_expect(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < model_len; i++)
                        push_expect(ST_DONE, model_words[i], i, i + 1 == model_len);
                end
            end
        endcase
    endfunction

    function automatic void queue_op(t_action a, int p, logic [VALUE_W-1:0] v);
        t_list_op op;
        op.action   = a;
        op.position = POS_W'(p);
        op.value    = v;
        pending_ops.push_back(op);
    endfunction

    // Mostly in-range positions and pool words, so removals by value find matches.
    function automatic t_list_op random_list_op(bit fill_bias);
        t_list_op op;
        int       roll;
        roll = $urandom_range(99);
        if (fill_bias)
            op.action = (roll < 60) ? ACT_INSERT : (roll < 75) ? ACT_REMOVE_AT :
                        (roll < 85) ? ACT_REMOVE_VAL : ACT_TRAVERSE;
        else
            op.action = (roll < 15) ? ACT_INSERT : (roll < 55) ? ACT_REMOVE_AT :
                        (roll < 85) ? ACT_REMOVE_VAL : ACT_TRAVERSE;
        op.position = ($urandom_range(99) < 75) ? POS_W'($urandom_range(0, 17))
                                                : POS_W'($urandom_range(0, 255));
        op.value = ($urandom_range(99) < 70) ? word_pool[$urandom_range(0, 7)]
                                             : VALUE_W'($urandom);
        return op;
    endfunction

    // Driver: advance to the next pending item once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) predict_list_op(drv_op);
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                drv_op   <= pending_ops.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expected one.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result status=%0d value=%h index=%0d count=%0d last=%b",
                             $time, o_status, o_element_value, o_element_index,
                             o_entry_count, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if ({o_status, o_element_value, o_element_index, o_entry_count, o_last}
                        !== want) begin
                        fail_count++;
                        $display("%0t: mismatch expected status=%0d value=%h index=%0d count=%0d last=%b",
                                 $time, want.status, want.element_value, want.element_index,
                                 want.entry_count, want.last);
                        $display("%0t:          actual   status=%0d value=%h index=%0d count=%0d last=%b",
                                 $time, o_status, o_element_value, o_element_index,
                                 o_entry_count, o_last);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_until_idle();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_match_mask(logic [MASK_W-1:0] m);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        model_mask = m;
    endtask

    initial begin
        logic [MASK_W-1:0] mask_plan [NUM_PHASES];
        mask_plan[0] = '1;
        mask_plan[1] = 32'h0000_FFFF;
        mask_plan[2] = '0;
        mask_plan[3] = MASK_W'($urandom);
        word_pool[0] = '0;
        word_pool[1] = '1;
        for (int i = 2; i < 8; i++) word_pool[i] = VALUE_W'($urandom);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_until_idle();
            write_match_mask(mask_plan[ph]);
            send_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 87 : 0;
            recv_stall_pct = (ph == 0) ? 87 : (ph == 1) ? 6 : 0;
            if (ph == 0) begin
                // empty list on traverse and both removals
                queue_op(ACT_TRAVERSE, 0, '0);
                queue_op(ACT_REMOVE_AT, 0, '0);
                queue_op(ACT_REMOVE_VAL, 0, '1);
                // fill to capacity: front, append past count, middle
                queue_op(ACT_INSERT, 0, '0);
                queue_op(ACT_INSERT, 255, '1);
                queue_op(ACT_INSERT, 1, 32'hA5A5_A5A5);
                for (int i = 0; i < 13; i++)
                    queue_op(ACT_INSERT, (i % 3 == 0) ? 0 : $urandom_range(0, 255),
                             VALUE_W'($urandom));
                queue_op(ACT_INSERT, 5, 32'h1234_5678);
                queue_op(ACT_TRAVERSE, 0, '0);
                queue_op(ACT_REMOVE_AT, 16, '0);
                queue_op(ACT_REMOVE_AT, 255, '0);
                queue_op(ACT_REMOVE_VAL, 0, 32'h5A5A_5A5A);
                queue_op(ACT_REMOVE_VAL, 0, 32'hA5A5_A5A5);
                queue_op(ACT_REMOVE_AT, 0, '0);
                queue_op(ACT_REMOVE_AT, 13, '0);
                queue_op(ACT_TRAVERSE, 0, '0);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
                pending_ops.push_back(random_list_op(n < RAND_PER_PHASE / 2));
        end
        wait_until_idle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
